/* rtl/pfse_pkg.sv */
// Shared types and constants for the Playfair stream encryptor.
// No dependencies; imported by every module of the block.
package pfse_pkg;

    // Key square geometry
    localparam int SQ_DIM    = 5;
    localparam int CODE_W    = 5;
    localparam int ROW_W     = SQ_DIM * CODE_W;
    localparam int IDX_W     = 3;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] KEY_ROW_0 = 3'd0;
    localparam logic [IDX_W-1:0] KEY_ROW_4 = 3'd4;

    // Letter codes and byte ranges
    localparam logic [CODE_W-1:0] PAD_X     = 5'd23;
    localparam logic [7:0]        UPPER_A   = 8'h41;
    localparam logic [7:0]        UPPER_Z   = 8'h5A;
    localparam logic [7:0]        LOWER_A   = 8'h61;
    localparam logic [7:0]        LOWER_Z   = 8'h7A;

    // Queue sizes (job queue between front and back, result queue at the output)
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = Q_AW + 1;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [SQ_DIM-1:0][SQ_DIM-1:0][CODE_W-1:0] square_t;

    // One enciphering job: a letter pair, or an empty end marker
    typedef struct packed {
        code_t a;
        code_t b;
        logic  marker;
        logic  last;
    } job_t;

    // One result word
    typedef struct packed {
        code_t letter;
        logic  valid;
        logic  missing;
        logic  last;
    } result_t;

    // Status the job queue reports to its neighbors
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Reset square: rows MFHIJ, KUNOP, QZVWX, YELAR, GDSTB
    localparam logic [SQ_DIM-1:0][ROW_W-1:0] KEY_RESET = {
        25'd1689702, 25'd17837208, 25'd24860464, 25'd16201354, 25'd9706668
    };

endpackage

/* rtl/pfse_front.sv */
// Front end: filters and folds message bytes, pairs letters and issues jobs.
// Depends on pfse_pkg.
module pfse_front
    import pfse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    output logic      full,
    input  logic [7:0] message_byte,
    input  logic      end_of_message,
    input  q_status_t q_status,
    output logic      q_push,
    output job_t      q_job
);

    code_t held_reg, held_next;
    logic  held_present_reg, held_present_next;
    logic  pend_valid_reg;
    job_t  pend_job_reg;

    logic       accept;
    logic       is_letter;
    code_t      code;
    logic [1:0] njobs;
    job_t       job1, job2, eom_job;

    assign full   = pend_valid_reg | q_status.full;
    assign accept = push & ~full;

    // Letter classification and case folding
    always_comb
    begin
        is_letter = 1'b0;
        code      = '0;
        if (message_byte >= UPPER_A && message_byte <= UPPER_Z)
        begin
            is_letter = 1'b1;
            code      = CODE_W'(message_byte - UPPER_A);
        end
        else if (message_byte >= LOWER_A && message_byte <= LOWER_Z)
        begin
            is_letter = 1'b1;
            code      = CODE_W'(message_byte - LOWER_A);
        end
    end

    // Pairing: up to two jobs per byte
    always_comb
    begin
        held_next         = held_reg;
        held_present_next = held_present_reg;
        njobs             = 2'd0;
        job1              = '0;
        job2              = '0;
        eom_job           = '0;
        if (is_letter)
        begin
            if (!held_present_reg)
            begin
                held_next         = code;
                held_present_next = 1'b1;
            end
            else if (held_reg == code)
            begin
                job1  = '{a: held_reg, b: PAD_X, marker: 1'b0, last: 1'b0};
                njobs = 2'd1;
            end
            else
            begin
                job1              = '{a: held_reg, b: code, marker: 1'b0, last: 1'b0};
                njobs             = 2'd1;
                held_next         = '0;
                held_present_next = 1'b0;
            end
        end
        if (end_of_message)
        begin
            if (held_present_next)
            begin
                eom_job = '{a: held_next, b: PAD_X, marker: 1'b0, last: 1'b1};
                if (njobs == 2'd0)
                    job1 = eom_job;
                else
                    job2 = eom_job;
                njobs             = njobs + 2'd1;
                held_next         = '0;
                held_present_next = 1'b0;
            end
            else if (njobs == 2'd0)
            begin
                job1  = '{a: '0, b: '0, marker: 1'b1, last: 1'b1};
                njobs = 2'd1;
            end
            else
            begin
                job1.last = 1'b1;
            end
        end
    end

    // Queue write: a pending second job goes first
    always_comb
    begin
        if (pend_valid_reg)
        begin
            q_push = ~q_status.full;
            q_job  = pend_job_reg;
        end
        else
        begin
            q_push = accept & (njobs != 2'd0);
            q_job  = job1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg         <= '0;
            held_present_reg <= 1'b0;
            pend_valid_reg   <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                held_reg         <= held_next;
                held_present_reg <= held_present_next;
                pend_valid_reg   <= (njobs == 2'd2);
            end
            else if (pend_valid_reg && !q_status.full)
            begin
                pend_valid_reg <= 1'b0;
            end
        end
    end

    // Second job payload
    always_ff @(posedge clk)
    begin
        if (accept)
            pend_job_reg <= job2;
    end

endmodule

/* rtl/pfse_job_queue.sv */
// Short job queue between front and back ends.
// Depends on pfse_pkg.
module pfse_job_queue
    import pfse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  job_t      wr_job,
    input  logic      rd_en,
    output job_t      rd_job,
    output q_status_t status
);

    job_t              mem [Q_DEPTH];
    logic [Q_AW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [Q_CW-1:0]   cnt_reg;
    logic              do_wr, do_rd;

    assign status.full  = (cnt_reg == Q_CW'(Q_DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign do_wr        = wr_en & ~status.full;
    assign do_rd        = rd_en & ~status.empty;
    assign rd_job       = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_reg + Q_CW'(do_wr) - Q_CW'(do_rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_job;
    end

endmodule

/* rtl/pfse_back.sv */
// Back end: looks up each pair in the key square and emits one cipher word
// per cycle into a small result queue while not full. Depends on pfse_pkg.
module pfse_back
    import pfse_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  square_t   square,
    input  q_status_t q_status,
    input  job_t      q_job,
    output logic      q_pop,
    output logic      empty,
    input  logic      pop,
    output result_t   result
);

    job_t            job_reg;
    logic            busy_reg;
    logic            phase_reg;
    result_t         oq_mem [Q_DEPTH];
    logic [Q_AW-1:0] oq_wr_reg, oq_rd_reg;
    logic [Q_CW-1:0] oq_cnt_reg;

    logic            f1, f2;
    logic [IDX_W-1:0] r1, c1, r2, c2;
    code_t           e1, e2;
    result_t         word;
    logic            emit, final_emit, load, do_pop;

    function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] x);
        return (x == IDX_W'(SQ_DIM - 1)) ? '0 : x + 1'b1;
    endfunction

    // Locate both letters; first match in row-major order wins
    always_comb
    begin
        f1 = 1'b0; r1 = '0; c1 = '0;
        f2 = 1'b0; r2 = '0; c2 = '0;
        for (int r = SQ_DIM - 1; r >= 0; r--)
        begin
            for (int c = SQ_DIM - 1; c >= 0; c--)
            begin
                if (square[r][c] == job_reg.a)
                begin
                    f1 = 1'b1; r1 = IDX_W'(r); c1 = IDX_W'(c);
                end
                if (square[r][c] == job_reg.b)
                begin
                    f2 = 1'b1; r2 = IDX_W'(r); c2 = IDX_W'(c);
                end
            end
        end
    end

    // Playfair rules: same row, same column, rectangle
    always_comb
    begin
        if (r1 == r2)
        begin
            e1 = square[r1][wrap_inc(c1)];
            e2 = square[r2][wrap_inc(c2)];
        end
        else if (c1 == c2)
        begin
            e1 = square[wrap_inc(r1)][c1];
            e2 = square[wrap_inc(r2)][c2];
        end
        else
        begin
            e1 = square[r1][c2];
            e2 = square[r2][c1];
        end
    end

    // Word for the current phase
    always_comb
    begin
        if (job_reg.marker)
            word = '{letter: '0, valid: 1'b0, missing: 1'b0, last: 1'b1};
        else if (!(f1 && f2))
            word = '{letter: '0, valid: 1'b1, missing: 1'b1,
                     last: job_reg.last & phase_reg};
        else
            word = '{letter: phase_reg ? e2 : e1, valid: 1'b1, missing: 1'b0,
                     last: job_reg.last & phase_reg};
    end

    assign emit       = busy_reg & (oq_cnt_reg != Q_CW'(Q_DEPTH));
    assign final_emit = emit & (job_reg.marker | phase_reg);
    assign load       = ~busy_reg | final_emit;
    assign q_pop      = load & ~q_status.empty;

    assign empty  = (oq_cnt_reg == '0);
    assign do_pop = pop & ~empty;
    assign result = oq_mem[oq_rd_reg];

    // Job sequencing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg  <= ~q_status.empty;
                phase_reg <= 1'b0;
            end
            else if (emit)
            begin
                phase_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            job_reg <= q_job;
    end

    // Result queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oq_wr_reg  <= '0;
            oq_rd_reg  <= '0;
            oq_cnt_reg <= '0;
        end
        else
        begin
            if (emit)
                oq_wr_reg <= oq_wr_reg + 1'b1;
            if (do_pop)
                oq_rd_reg <= oq_rd_reg + 1'b1;
            oq_cnt_reg <= oq_cnt_reg + Q_CW'(emit) - Q_CW'(do_pop);
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
            oq_mem[oq_wr_reg] <= word;
    end

endmodule

/* rtl/playfair_stream_encryptor.sv */
// Path: the first cipher word of a byte goes through the job queue and the back
// end's job register into the result queue. Throughput: one byte per cycle
// while the job queue has room, with a stall after a byte that gives two pairs
// until its second job is written; one result word per cycle while the result
// queue has room, set by the single lookup unit in the back end.
// Reset: key square returns to its default, no letter held, both queues empty.
module playfair_stream_encryptor
    import pfse_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  logic [7:0]        message_byte,
    input  logic              end_of_message,
    output logic              empty,
    input  logic              pop,
    output logic [CODE_W-1:0] cipher_letter,
    output logic              letter_valid,
    output logic              not_in_square,
    output logic              last_of_message,
    input  logic              cfg_wr_en,
    input  logic [IDX_W-1:0]  cfg_index,
    input  logic [ROW_W-1:0]  cfg_wdata
);

    logic [SQ_DIM-1:0][ROW_W-1:0] key_row_reg;
    square_t   square;
    q_status_t q_status;
    logic      q_push, q_pop;
    job_t      push_job, pop_job;
    result_t   result;

    // Key square registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_row_reg <= KEY_RESET;
        else if (cfg_wr_en && cfg_index >= KEY_ROW_0 && cfg_index <= KEY_ROW_4)
            key_row_reg[cfg_index] <= cfg_wdata;
    end

    assign square = square_t'(key_row_reg);

    pfse_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .message_byte   (message_byte),
        .end_of_message (end_of_message),
        .q_status       (q_status),
        .q_push         (q_push),
        .q_job          (push_job)
    );

    pfse_job_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_push),
        .wr_job (push_job),
        .rd_en  (q_pop),
        .rd_job (pop_job),
        .status (q_status)
    );

    pfse_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .square   (square),
        .q_status (q_status),
        .q_job    (pop_job),
        .q_pop    (q_pop),
        .empty    (empty),
        .pop      (pop),
        .result   (result)
    );

    assign cipher_letter   = result.letter;
    assign letter_valid    = result.valid;
    assign not_in_square   = result.missing;
    assign last_of_message = result.last;

endmodule

/* rtl/pfse_checker.sv */
// Port-level checks for the Playfair stream encryptor, bound to the top level.
// Depends on pfse_pkg.
module pfse_checker
    import pfse_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              empty,
    input logic              pop,
    input logic [CODE_W-1:0] cipher_letter,
    input logic              letter_valid,
    input logic              not_in_square,
    input logic              last_of_message
);

    // An end marker carries no letter and closes a message
    a_marker_form: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !letter_valid) |-> (last_of_message && cipher_letter == '0
                                       && !not_in_square))
        else $error("end marker word malformed");

    // A missing-letter word carries code zero as a letter
    a_missing_form: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && not_in_square) |-> (letter_valid && cipher_letter == '0))
        else $error("missing-letter word malformed");

    // A waiting word holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(cipher_letter)
                              && $stable(letter_valid) && $stable(last_of_message)))
        else $error("result word changed while waiting");

endmodule

bind playfair_stream_encryptor pfse_checker u_pfse_checker (.*);

/* tb/sv/playfair_stream_encryptor_tb.sv */
// Self-checking testbench for playfair_stream_encryptor: a Playfair model scoreboard
// plus queue-style drivers, with directed bytes, random messages and several key squares.
// Depends on pfse_pkg and the playfair_stream_encryptor RTL.

// Scoreboard: Playfair model with its own key square and held-letter state
class cipher_scoreboard;
    logic [pfse_pkg::ROW_W-1:0]  key_rows [pfse_pkg::SQ_DIM];
    pfse_pkg::code_t             held_code;
    bit                          held_valid;
    pfse_pkg::result_t           expected_words [$];
    pfse_pkg::result_t           step_words [$];
    int                          errors;

    function new();
        for (int r = 0; r < pfse_pkg::SQ_DIM; r++)
        begin
            key_rows[r] = pfse_pkg::KEY_RESET[r];
        end
        held_code  = '0;
        held_valid = 1'b0;
        errors     = 0;
    endfunction

    function void set_row(logic [pfse_pkg::IDX_W-1:0] idx, logic [pfse_pkg::ROW_W-1:0] val);
        // indexes past the last row are dropped by the block
        if (idx <= pfse_pkg::KEY_ROW_4)
        begin
            key_rows[idx] = val;
        end
    endfunction

    function pfse_pkg::code_t entry(int r, int c);
        return key_rows[r % pfse_pkg::SQ_DIM][(c % pfse_pkg::SQ_DIM) * pfse_pkg::CODE_W +:
                                              pfse_pkg::CODE_W];
    endfunction

    // first match in row-major order wins
    function bit locate_code(pfse_pkg::code_t code, output int r, output int c);
        r = 0;
        c = 0;
        for (int i = 0; i < pfse_pkg::SQ_DIM; i++)
        begin
            for (int j = 0; j < pfse_pkg::SQ_DIM; j++)
            begin
                if (entry(i, j) == code)
                begin
                    r = i;
                    c = j;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    function void add_word(pfse_pkg::code_t letter, logic valid, logic missing);
        pfse_pkg::result_t w;
        w.letter  = letter;
        w.valid   = valid;
        w.missing = missing;
        w.last    = 1'b0;
        step_words.push_back(w);
    endfunction

    // Encipher one pair into two words
    function void encipher_pair(pfse_pkg::code_t a, pfse_pkg::code_t b);
        int  r1, c1, r2, c2;
        bit  f1, f2;
        f1 = locate_code(a, r1, c1);
        f2 = locate_code(b, r2, c2);
        if (!f1 || !f2)
        begin
            add_word('0, 1'b1, 1'b1);
            add_word('0, 1'b1, 1'b1);
        end
        else if (r1 == r2)
        begin
            add_word(entry(r1, c1 + 1), 1'b1, 1'b0);
            add_word(entry(r2, c2 + 1), 1'b1, 1'b0);
        end
        else if (c1 == c2)
        begin
            add_word(entry(r1 + 1, c1), 1'b1, 1'b0);
            add_word(entry(r2 + 1, c2), 1'b1, 1'b0);
        end
        else
        begin
            add_word(entry(r1, c2), 1'b1, 0);
            add_word(entry(r2, c1), 1'b1, 0);
        end
    endfunction

    // Accepted input byte: update held letter and queue the words it causes
    function void encipher_byte(logic [7:0] b, logic eom);
        pfse_pkg::code_t code;
        bit              is_letter;
        is_letter = 1'b0;
        code      = '0;
        step_words.delete();
        if (b >= pfse_pkg::UPPER_A && b <= pfse_pkg::UPPER_Z)
        begin
            is_letter = 1'b1;
            code      = pfse_pkg::CODE_W'(b - pfse_pkg::UPPER_A);
        end
        else if (b >= pfse_pkg::LOWER_A && b <= pfse_pkg::LOWER_Z)
        begin
            is_letter = 1'b1;
            code      = pfse_pkg::CODE_W'(b - pfse_pkg::LOWER_A);
        end

        if (is_letter)
        begin
            if (!held_valid)
            begin
                held_code  = code;
                held_valid = 1'b1;
            end
            else if (held_code == code)
            begin
                // doubled letter: pad with X, keep the new one held
                encipher_pair(held_code, pfse_pkg::PAD_X);
                held_code = code;
            end
            else
            begin
                encipher_pair(held_code, code);
                held_code  = '0;
                held_valid = 1'b0;
            end
        end

        if (eom)
        begin
            if (held_valid)
            begin
                encipher_pair(held_code, pfse_pkg::PAD_X);
                held_code  = '0;
                held_valid = 1'b0;
            end
            // nothing to send: empty end marker
            if (step_words.size() == 0)
            begin
                add_word('0, 1'b0, 1'b0);
            end
            step_words[step_words.size() - 1].last = 1'b1;
        end

        foreach (step_words[k])
        begin
            expected_words.push_back(step_words[k]);
        end
    endfunction

    function int pending();
        return expected_words.size();
    endfunction

    task report(string msg);
        if (errors < 100)
        begin
            $display("ERROR @%0t: %s", $time, msg);
        end
        errors++;
    endtask

    // Compare one accepted word with the oldest expectation
    task check_word(pfse_pkg::result_t got);
        pfse_pkg::result_t want;
        if (expected_words.size() == 0)
        begin
            report($sformatf("unexpected word letter=%0d valid=%0b missing=%0b last=%0b",
                             got.letter, got.valid, got.missing, got.last));
            return;
        end
        want = expected_words.pop_front();
        if (got.letter !== want.letter)
        begin
            report($sformatf("cipher_letter %0d, expected %0d", got.letter, want.letter));
        end
        if (got.valid !== want.valid)
        begin
            report($sformatf("letter_valid %0b, expected %0b", got.valid, want.valid));
        end
        if (got.missing !== want.missing)
        begin
            report($sformatf("not_in_square %0b, expected %0b", got.missing, want.missing));
        end
        if (got.last !== want.last)
        begin
            report($sformatf("last_of_message %0b, expected %0b", got.last, want.last));
        end
    endtask
endclass

module playfair_stream_encryptor_tb;
    import pfse_pkg::*;

    typedef logic [SQ_DIM-1:0][ROW_W-1:0] key_rows_t;

    localparam int MAX_GAP       = 6;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_LIMIT    = 2000;  // far above gap + stall + latency

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    logic [7:0]        message_byte;
    logic              end_of_message;
    logic              empty;
    logic              pop;
    logic [CODE_W-1:0] cipher_letter;
    logic              letter_valid;
    logic              not_in_square;
    logic              last_of_message;
    logic              cfg_wr_en;
    logic [IDX_W-1:0]  cfg_index;
    logic [ROW_W-1:0]  cfg_wdata;

    bit                no_idle;
    int                idle_cycles = 0;
    cipher_scoreboard  sb = new();

    playfair_stream_encryptor DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .push            (push),
        .full            (full),
        .message_byte    (message_byte),
        .end_of_message  (end_of_message),
        .empty           (empty),
        .pop             (pop),
        .cipher_letter   (cipher_letter),
        .letter_valid    (letter_valid),
        .not_in_square   (not_in_square),
        .last_of_message (last_of_message),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, MAX_GAP);
    endfunction

    function automatic bit is_letter_byte(logic [7:0] b);
        return (b >= UPPER_A && b <= UPPER_Z) || (b >= LOWER_A && b <= LOWER_Z);
    endfunction

    // Letters lean toward A-D so doubles and shared rows come up often
    function automatic logic [7:0] random_letter();
        logic [4:0] code;
        code = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 3)) : 5'($urandom_range(0, 25));
        return ($urandom_range(0, 1) ? LOWER_A : UPPER_A) + 8'(code);
    endfunction

    // Push one byte, hold it until accepted
    task automatic send_byte(logic [7:0] b, logic eom);
        int gap;
        gap = draw_gap();
        repeat (gap)
        begin
            @(negedge clk);
            push <= 1'b0;
        end
        @(negedge clk);
        push           <= 1'b1;
        message_byte   <= b;
        end_of_message <= eom;
        do @(posedge clk); while (full !== 1'b0);
        sb.encipher_byte(b, eom);
    endtask

    task automatic send_text(string s, bit eom_at_end);
        for (int i = 0; i < s.len(); i++)
        begin
            send_byte(s[i], eom_at_end && (i == s.len() - 1));
        end
    endtask

    // Stop sending and wait for every expected word
    task automatic drain_results();
        @(negedge clk);
        push <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic wait_idle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [ROW_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        sb.set_row(idx, val);
    endtask

    // All five rows, plus a write to an unused index that must be dropped
    task automatic load_square(key_rows_t rows);
        for (int r = 0; r < SQ_DIM; r++)
        begin
            write_reg(IDX_W'(r), rows[r]);
        end
        write_reg(IDX_W'($urandom_range(int'(KEY_ROW_4) + 1, 7)), ROW_W'($urandom));
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Random messages; n counts letters and end bytes only
    task automatic random_traffic(int n);
        int          count;
        int          len;
        logic [7:0]  b;
        logic        eom;
        count = 0;
        while (count < n)
        begin
            len     = $urandom_range(1, 10);
            no_idle = ($urandom_range(0, 3) == 0);
            for (int i = 0; i < len; i++)
            begin
                if ($urandom_range(0, 5) == 0)
                    b = 8'($urandom_range(0, 255));
                else
                    b = random_letter();
                // now and then a message runs on without its end byte
                eom = (i == len - 1) && ($urandom_range(0, 7) != 0);
                send_byte(b, eom);
                if (eom || is_letter_byte(b))
                begin
                    count++;
                end
            end
        end
        no_idle = 1'b0;
    endtask

    // Result side: random stalls, check each accepted word
    initial
    begin
        result_t got;
        int      gap;
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_gap();
            repeat (gap)
            begin
                @(negedge clk);
                pop <= 1'b0;
            end
            @(negedge clk);
            pop <= 1'b1;
            do @(posedge clk); while (empty !== 1'b0);
            got.letter  = cipher_letter;
            got.valid   = letter_valid;
            got.missing = not_in_square;
            got.last    = last_of_message;
            sb.check_word(got);
        end
    end

    // Watchdog: too long with no word moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (push && !full) || (pop && !empty))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("** playfair_stream_encryptor: FAILED **");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Main sequence
    initial
    begin
        key_rows_t  rows;
        int         letters [26];
        int         j;
        int         t;

        rst_n          = 1'b0;
        push           = 1'b0;
        message_byte   = '0;
        end_of_message = 1'b0;
        cfg_wr_en      = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        no_idle        = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed, reset square: row, column, rectangle, doubles, case folding
        send_text("MFMKMU", 1'b0);
        send_text("AAb", 1'b0);
        // doubled X, then end on a non-letter pads the held X
        send_text("XX!", 1'b1);
        // C is absent from the reset square
        send_text("CA", 1'b0);
        // end with nothing held: empty marker
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        // bytes just outside the letter ranges
        send_text("@[`{", 1'b0);
        // doubled letter on the end byte gives four words
        send_text("Zz", 1'b1);
        send_text("a", 1'b1);
        send_text("qR", 1'b1);

        // Random, reset square, with a full pause in the middle
        random_traffic(25);
        drain_results();
        random_traffic(25);
        wait_idle();

        // Random permutation of the 26 letters; the first 25 fill the square
        foreach (letters[k])
        begin
            letters[k] = k;
        end
        for (int k = 25; k > 0; k--)
        begin
            j          = $urandom_range(0, k);
            t          = letters[k];
            letters[k] = letters[j];
            letters[j] = t;
        end
        for (int k = 0; k < SQ_DIM * SQ_DIM; k++)
        begin
            rows[k / SQ_DIM][(k % SQ_DIM) * CODE_W +: CODE_W] = CODE_W'(letters[k]);
        end
        load_square(rows);
        random_traffic(40);
        wait_idle();

        // Fully random rows: duplicates and codes above Z
        for (int r = 0; r < SQ_DIM; r++)
        begin
            rows[r] = ROW_W'($urandom);
        end
        load_square(rows);
        random_traffic(30);
        wait_idle();

        // Extremes: all zero, then all ones
        load_square('0);
        random_traffic(15);
        wait_idle();
        load_square('1);
        random_traffic(15);
        wait_idle();

        if (sb.errors == 0)
            $display("** playfair_stream_encryptor: PASSED **");
        else
            $display("** playfair_stream_encryptor: FAILED **");
        $finish;
    end

endmodule
